/* design/two_view_triangulate_inliers_defines.svh */
// Assertion macros shared by the triangulation block.
// They assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef TWO_VIEW_TRIANGULATE_INLIERS_DEFINES_SVH
`define TWO_VIEW_TRIANGULATE_INLIERS_DEFINES_SVH
`ifndef ASSERT_OFF
`define TVT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("tvt check failed");
`define TVT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("tvt check failed");
`else
`define TVT_ASSERT(lbl, prop)
`define TVT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* design/tvt_pkg.sv */
package tvt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int INDEX_BITS = 16;

	// Shared multiplier operands and accumulator.
	localparam int MAC_W  = 34;
	localparam int ACC_W  = 2 * MAC_W;
	// Divider dividend is a 32-bit value scaled up by the fraction bits.
	localparam int DIV_NW = 32 + FRAC_BITS;
	localparam int DIV_CW = $clog2(DIV_NW);
	// Left ray term l0 * f1 after the fraction shift.
	localparam int XM_W   = 51 - FRAC_BITS;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [53:0] ROT_ONE = 54'(1 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT0,
		REG_ROT1,
		REG_ROT2,
		REG_TRANS,
		REG_ERR_THR,
		REG_ERR_SCALE
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic clear;
		logic neg;
	} mac_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7fff_ffff);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
	localparam logic [47:0] SUM_MAX = '1;

	// Symmetric saturation to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fff_ffff;
		end else if (v < SAT_LO) begin
			r = -32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* design/tvt_if.sv */
interface tvt_pair_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] first_x;
	logic signed [17:0] first_y;
	logic signed [17:0] first_z;
	logic signed [17:0] second_x;
	logic signed [17:0] second_y;
	logic signed [17:0] second_z;
	logic               start_of_set;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		start_of_set, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		start_of_set, output ready);
endinterface

interface tvt_result_if;
	logic               valid;
	logic               ready;
	logic        [15:0] pair_index;
	logic               is_inlier;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic        [47:0] error_total;
	logic               degenerate;

	modport source (output valid, pair_index, is_inlier, point_x, point_y, point_z,
		error_total, degenerate, input ready);
	modport sink (input valid, pair_index, is_inlier, point_x, point_y, point_z,
		error_total, degenerate, output ready);
endinterface

interface tvt_cfg_if import tvt_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/tvt_mac.sv */
module tvt_mac import tvt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_req_t                req,
	input  logic signed [MAC_W-1:0] op_a,
	input  logic signed [MAC_W-1:0] op_b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*MAC_W-1:0] prod_s1;
	mac_req_t                  ctl_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign base = ctl_s1.clear ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= ctl_s1.neg ? base - ACC_W'(prod_s1) : base + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

/* design/tvt_div.sv */
module tvt_div import tvt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIV_NW-1:0] dividend,
	input  logic signed [31:0]       divisor,
	output unit_stat_t               stat,
	output logic signed [DIV_NW:0]   quotient
);

	logic [DIV_NW-1:0] quo_q;
	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [32:0]       shifted;
	logic [32:0]       diff;
	logic              take;

	// Restoring division on magnitudes, one quotient bit a cycle.
	always_comb begin
		shifted = {rem_q, quo_q[DIV_NW-1]};
		diff    = shifted - {1'b0, den_q};
		take    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DIV_NW-1] ? DIV_NW'(-dividend) : DIV_NW'(dividend);
			rem_q <= '0;
			den_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
			neg_q <= dividend[DIV_NW-1] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= take ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[DIV_NW-2:0], take};
		end
	end

	// Sign applied to the magnitude gives truncation toward zero.
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

/* design/tvt_isqrt.sv */
module tvt_isqrt import tvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output unit_stat_t  stat,
	output logic [31:0] root
);

	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        take;

	// Two radicand bits enter each cycle and one root bit is decided.
	always_comb begin
		rem_sh = {rem_q, val_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[61:0], 2'b00};
			rem_q  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], take};
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

/* design/two_view_triangulate_inliers.sv */
// A request runs the full test, or stops early when the solve is singular or when a depth
// is zero. A new pair is taken only in the idle state, and ten divider passes take most
// of the full case. A result waits in the output register while the next pair is
// taken in, and the pair after that waits in the last state until the register is free.
// Reset restores the default rotation, translation, threshold and scale,
// and clears the pair counter, the error sum and any pending result.
`include "two_view_triangulate_inliers_defines.svh"
module two_view_triangulate_inliers import tvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tvt_cfg_if.sink       cfg,
	tvt_pair_if.sink      pair_in,
	tvt_result_if.source  result_out
);

	typedef enum logic [4:0] {
		S_IDLE, S_G, S_B0, S_B1, S_A, S_C, S_D, S_DET, S_N0, S_DV0, S_N1, S_DV1,
		S_XM, S_XN, S_Q, S_ZCHK, S_PJ, S_SQ, S_RT, S_SC, S_FIN
	} state_t;

	state_t state_q;
	logic [2:0] k_q;
	logic [1:0] i_q;
	logic       v_q;
	logic       degen_q;

	logic [53:0] rot_q [3];
	logic [62:0] trans_q;
	logic [31:0] thr_q;
	logic [31:0] scale_q;

	logic [INDEX_BITS-1:0] cnt_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [47:0]           sum_q;

	logic signed [17:0] f1_q [3];
	logic signed [17:0] f2_q [3];
	logic signed [31:0] g_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] q_q [3];
	logic signed [31:0] pj_q [4];
	logic signed [31:0] a_q, b0_q, b1_q, c_q, d_q, det_q, num_q, l0_q, l1_q;
	logic signed [XM_W-1:0] xm_q;
	logic [63:0] sq_q;
	logic [31:0] n_q;
	logic [31:0] e_q [2];

	logic               out_valid_q;
	logic [15:0]        oidx_q;
	logic               oinl_q;
	logic signed [31:0] opx_q, opy_q, opz_q;
	logic [47:0]        otot_q;
	logic               odeg_q;

	logic signed [17:0]      rot_e [3][3];
	logic signed [20:0]      t_e [3];
	logic signed [MAC_W-1:0] d3 [3];
	logic [1:0]              kk;
	logic [2:0]              nterms;
	logic                    mac_state;
	logic                    mac_done;
	mac_req_t                mac_req;
	logic signed [MAC_W-1:0] mac_a, mac_b;
	logic signed [ACC_W-1:0] acc, acc_sh, xsum;
	logic signed [31:0]      res32, dx, dy;
	logic [31:0]             esat;

	logic                     div_start;
	logic signed [DIV_NW-1:0] div_dividend;
	logic signed [31:0]       div_divisor;
	unit_stat_t               div_stat;
	logic signed [DIV_NW:0]   div_quot;
	logic                     sq_start;
	unit_stat_t               sq_stat;
	logic [31:0]              sq_root;

	logic signed [31:0] u_x, u_y, u_z, w_x, w_y, w_z, sel_x, sel_z;
	logic               inl;
	logic [49:0]        sum_w;
	logic [47:0]        sum_sat;
	logic               load_out;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot_e[i][j] = rot_q[i][18*j +: 18];
			end
			t_e[i] = trans_q[21*i +: 21];
			d3[i]  = MAC_W'(p_q[i]) - MAC_W'(t_e[i]);
		end
	end

	assign kk = k_q[1:0];

	// Operand selection for the shared multiply-accumulate unit.
	always_comb begin
		mac_state = 1'b1;
		nterms    = 3'd3;
		mac_a     = '0;
		mac_b     = '0;
		mac_req.neg = 1'b0;
		case (state_q)
			S_G: begin
				mac_a = MAC_W'(rot_e[i_q][kk]);
				mac_b = MAC_W'(f2_q[kk]);
			end
			S_B0: begin
				mac_a = MAC_W'(t_e[kk]);
				mac_b = MAC_W'(f1_q[kk]);
			end
			S_B1: begin
				mac_a = MAC_W'(t_e[kk]);
				mac_b = MAC_W'(g_q[kk]);
			end
			S_A: begin
				mac_a = MAC_W'(f1_q[kk]);
				mac_b = MAC_W'(f1_q[kk]);
			end
			S_C: begin
				mac_a = MAC_W'(f1_q[kk]);
				mac_b = MAC_W'(g_q[kk]);
			end
			S_D: begin
				mac_a = MAC_W'(g_q[kk]);
				mac_b = MAC_W'(g_q[kk]);
			end
			S_DET: begin
				nterms      = 3'd2;
				mac_a       = kk[0] ? MAC_W'(a_q) : MAC_W'(c_q);
				mac_b       = kk[0] ? MAC_W'(d_q) : MAC_W'(c_q);
				mac_req.neg = kk[0];
			end
			S_N0: begin
				nterms      = 3'd2;
				mac_a       = kk[0] ? MAC_W'(d_q) : MAC_W'(c_q);
				mac_b       = kk[0] ? MAC_W'(b0_q) : MAC_W'(b1_q);
				mac_req.neg = kk[0];
			end
			S_N1: begin
				nterms      = 3'd2;
				mac_a       = kk[0] ? MAC_W'(c_q) : MAC_W'(a_q);
				mac_b       = kk[0] ? MAC_W'(b0_q) : MAC_W'(b1_q);
				mac_req.neg = kk[0];
			end
			S_XM: begin
				nterms = 3'd1;
				mac_a  = MAC_W'(l0_q);
				mac_b  = MAC_W'(f1_q[i_q]);
			end
			S_XN: begin
				nterms = 3'd1;
				mac_a  = MAC_W'(l1_q);
				mac_b  = MAC_W'(g_q[i_q]);
			end
			S_Q: begin
				mac_a = MAC_W'(rot_e[kk][i_q]);
				mac_b = d3[kk];
			end
			S_SQ: begin
				nterms = 3'd2;
				mac_a  = kk[0] ? MAC_W'(dy) : MAC_W'(dx);
				mac_b  = kk[0] ? MAC_W'(dy) : MAC_W'(dx);
			end
			S_SC: begin
				nterms = 3'd1;
				mac_a  = MAC_W'({1'b0, scale_q});
				mac_b  = MAC_W'({1'b0, n_q});
			end
			default: begin
				mac_state = 1'b0;
				nterms    = 3'd0;
			end
		endcase
		mac_req.valid = mac_state && (k_q < nterms);
		mac_req.clear = (k_q == 3'd0);
		mac_done      = mac_state && (k_q == nterms + 3'd1);
	end

	tvt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (acc)
	);

	always_comb begin
		acc_sh = acc >>> FRAC_BITS;
		res32  = sat32(acc_sh);
		xsum   = ACC_W'(xm_q) + ACC_W'(t_e[i_q]) + acc_sh;
		esat   = (|acc_sh[ACC_W-1:32]) ? '1 : acc_sh[31:0];
		dx     = sat32(ACC_W'(pj_q[0]) - ACC_W'(pj_q[2]));
		dy     = sat32(ACC_W'(pj_q[1]) - ACC_W'(pj_q[3]));
	end

	// Projection operands: the bearing and the point of the current view.
	always_comb begin
		u_x   = v_q ? 32'(f2_q[0]) : 32'(f1_q[0]);
		u_y   = v_q ? 32'(f2_q[1]) : 32'(f1_q[1]);
		u_z   = v_q ? 32'(f2_q[2]) : 32'(f1_q[2]);
		w_x   = v_q ? q_q[0] : p_q[0];
		w_y   = v_q ? q_q[1] : p_q[1];
		w_z   = v_q ? q_q[2] : p_q[2];
		sel_x = i_q[1] ? (i_q[0] ? w_y : w_x) : (i_q[0] ? u_y : u_x);
		sel_z = i_q[1] ? w_z : u_z;
	end

	always_comb begin
		div_start    = (state_q == S_DV0 || state_q == S_DV1 || state_q == S_PJ) && k_q == 3'd0;
		div_dividend = (state_q == S_PJ) ? $signed({sel_x, {FRAC_BITS{1'b0}}})
			: $signed({num_q, {FRAC_BITS{1'b0}}});
		div_divisor  = (state_q == S_PJ) ? sel_z : det_q;
		sq_start     = (state_q == S_RT) && k_q == 3'd0;
	end

	tvt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	tvt_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_q),
		.stat   (sq_stat),
		.root   (sq_root)
	);

	always_comb begin
		inl      = !degen_q && (e_q[0] <= thr_q) && (e_q[1] <= thr_q);
		sum_w    = 50'(sum_q) + 50'(e_q[0]) + 50'(e_q[1]);
		sum_sat  = (sum_w > 50'(SUM_MAX)) ? SUM_MAX : sum_w[47:0];
		load_out = (state_q == S_FIN) && (!out_valid_q || result_out.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			i_q         <= '0;
			v_q         <= 1'b0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			rot_q[0]    <= ROT_ONE;
			rot_q[1]    <= ROT_ONE << 18;
			rot_q[2]    <= ROT_ONE << 36;
			trans_q     <= '0;
			thr_q       <= 32'(2 << FRAC_BITS);
			scale_q     <= 32'(1 << FRAC_BITS);
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_ROT0:      rot_q[0] <= cfg.data[53:0];
					REG_ROT1:      rot_q[1] <= cfg.data[53:0];
					REG_ROT2:      rot_q[2] <= cfg.data[53:0];
					REG_TRANS:     trans_q  <= cfg.data[62:0];
					REG_ERR_THR:   thr_q    <= cfg.data[31:0];
					REG_ERR_SCALE: scale_q  <= cfg.data[31:0];
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mac_state) begin
				k_q <= mac_done ? 3'd0 : k_q + 3'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pair_in.valid) begin
						if (pair_in.start_of_set) begin
							cnt_q <= INDEX_BITS'(1);
							sum_q <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						k_q     <= '0;
						i_q     <= '0;
						v_q     <= 1'b0;
						degen_q <= 1'b0;
						state_q <= S_G;
					end
				end
				S_G: begin
					if (mac_done) begin
						i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
						if (i_q == 2'd2) begin
							state_q <= S_B0;
						end
					end
				end
				S_B0: if (mac_done) state_q <= S_B1;
				S_B1: if (mac_done) state_q <= S_A;
				S_A:  if (mac_done) state_q <= S_C;
				S_C:  if (mac_done) state_q <= S_D;
				S_D:  if (mac_done) state_q <= S_DET;
				S_DET: begin
					if (mac_done) begin
						if (res32 == 32'sd0) begin
							degen_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_N0;
						end
					end
				end
				S_N0: if (mac_done) state_q <= S_DV0;
				S_N1: if (mac_done) state_q <= S_DV1;
				S_DV0, S_DV1: begin
					if (k_q == 3'd0) begin
						k_q <= 3'd1;
					end else if (div_stat.done) begin
						k_q     <= '0;
						i_q     <= '0;
						state_q <= (state_q == S_DV0) ? S_N1 : S_XM;
					end
				end
				S_XM: if (mac_done) state_q <= S_XN;
				S_XN: begin
					if (mac_done) begin
						i_q     <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
						state_q <= (i_q == 2'd2) ? S_Q : S_XM;
					end
				end
				S_Q: begin
					if (mac_done) begin
						i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
						if (i_q == 2'd2) begin
							state_q <= S_ZCHK;
						end
					end
				end
				S_ZCHK: begin
					// Any zero depth makes the pair degenerate; the point still goes out.
					if (f1_q[2] == 18'sd0 || p_q[2] == 32'sd0 || f2_q[2] == 18'sd0
						|| q_q[2] == 32'sd0) begin
						degen_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						k_q     <= '0;
						i_q     <= '0;
						v_q     <= 1'b0;
						state_q <= S_PJ;
					end
				end
				S_PJ: begin
					if (k_q == 3'd0) begin
						k_q <= 3'd1;
					end else if (div_stat.done) begin
						k_q <= '0;
						i_q <= i_q + 2'd1;
						if (i_q == 2'd3) begin
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: if (mac_done) state_q <= S_RT;
				S_RT: begin
					if (k_q == 3'd0) begin
						k_q <= 3'd1;
					end else if (sq_stat.done) begin
						k_q     <= '0;
						state_q <= S_SC;
					end
				end
				S_SC: begin
					if (mac_done) begin
						v_q     <= 1'b1;
						state_q <= v_q ? S_FIN : S_PJ;
					end
				end
				S_FIN: begin
					if (load_out) begin
						if (inl) begin
							sum_q <= sum_sat;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pair_in.valid) begin
			f1_q[0] <= pair_in.first_x;
			f1_q[1] <= pair_in.first_y;
			f1_q[2] <= pair_in.first_z;
			f2_q[0] <= pair_in.second_x;
			f2_q[1] <= pair_in.second_y;
			f2_q[2] <= pair_in.second_z;
			idx_q   <= pair_in.start_of_set ? '0 : cnt_q;
		end
		if (mac_done) begin
			case (state_q)
				S_G:  g_q[i_q] <= res32;
				S_B0: b0_q <= res32;
				S_B1: b1_q <= res32;
				S_A:  a_q <= res32;
				S_C:  c_q <= res32;
				S_D:  d_q <= res32;
				S_DET: begin
					det_q <= res32;
					// A singular solve reports the origin.
					for (int i = 0; i < 3; i++) begin
						p_q[i] <= '0;
					end
				end
				S_N0, S_N1: num_q <= res32;
				S_XM: xm_q <= XM_W'(acc_sh);
				S_XN: p_q[i_q] <= sat32(xsum >>> 1);
				S_Q:  q_q[i_q] <= res32;
				S_SQ: sq_q <= acc[63:0];
				S_SC: e_q[v_q] <= esat;
				default: ;
			endcase
		end
		if (div_stat.done) begin
			case (state_q)
				S_DV0: l0_q <= sat32(ACC_W'(div_quot));
				S_DV1: l1_q <= sat32(ACC_W'(div_quot));
				S_PJ:  pj_q[i_q] <= sat32(ACC_W'(div_quot));
				default: ;
			endcase
		end
		if (state_q == S_RT && sq_stat.done) begin
			n_q <= sq_root;
		end
		if (load_out) begin
			oidx_q <= 16'(idx_q);
			oinl_q <= inl;
			opx_q  <= p_q[0];
			opy_q  <= p_q[1];
			opz_q  <= p_q[2];
			otot_q <= inl ? sum_sat : sum_q;
			odeg_q <= degen_q;
		end
	end

	assign pair_in.ready          = (state_q == S_IDLE);
	assign cfg.ready              = 1'b1;
	assign result_out.valid       = out_valid_q;
	assign result_out.pair_index  = oidx_q;
	assign result_out.is_inlier   = oinl_q;
	assign result_out.point_x     = opx_q;
	assign result_out.point_y     = opy_q;
	assign result_out.point_z     = opz_q;
	assign result_out.error_total = otot_q;
	assign result_out.degenerate  = odeg_q;

	`TVT_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN))
	`TVT_ASSERT(a_degen_not_inlier, out_valid_q |-> !(odeg_q && oinl_q))
	`TVT_ASSERT_ALWAYS(a_one_unit_busy, !(div_stat.busy && sq_stat.busy))

endmodule
